// File: hdl/rbca_pkg.sv
// ----------------------------------------------------------------------------
// rbca_pkg: shared types and constants
// Field widths, command and status codes for the rover block cache allocator.
// ----------------------------------------------------------------------------
package rbca_pkg;

	localparam int CMD_W    = 2;
	localparam int OID_W    = 10;
	localparam int WID_W    = 16;
	localparam int DATA_W   = 16;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 16;
	localparam int BYTES_W  = 17;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FLUSH  = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_MARK   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_OVERSIZE = 2'd2
	} status_t;

endpackage

// File: hdl/rbca_req_if.sv
// ----------------------------------------------------------------------------
// rbca_req_if: command channel
// Valid/ready channel that carries one allocator command per transaction.
// ----------------------------------------------------------------------------
interface rbca_req_if;
	import rbca_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [OID_W-1:0]  owner_id;
	logic [WID_W-1:0]  block_width;
	logic [DATA_W-1:0] data_bytes;

	modport source (output valid, command, owner_id, block_width, data_bytes, input ready);
	modport sink (input valid, command, owner_id, block_width, data_bytes, output ready);

endinterface

// File: hdl/rbca_rsp_if.sv
// ----------------------------------------------------------------------------
// rbca_rsp_if: result channel
// Valid/ready channel that carries one allocator result per transaction.
// ----------------------------------------------------------------------------
interface rbca_rsp_if;
	import rbca_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_addr;
	logic [BYTES_W-1:0]  block_bytes;
	logic                owner_valid;
	logic [WID_W-1:0]    stored_width;
	logic                thrash;

	modport source (output valid, status, block_addr, block_bytes, owner_valid, stored_width,
		thrash, input ready);
	modport sink (input valid, status, block_addr, block_bytes, owner_valid, stored_width,
		thrash, output ready);

endinterface

// File: hdl/rbca_ram.sv
// ----------------------------------------------------------------------------
// rbca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rbca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/rover_block_cache_allocator.sv
// ----------------------------------------------------------------------------
// rover_block_cache_allocator: rover-swept block allocator
// Keeps an arena as address-ordered blocks; allocates at the rover, merging
// following blocks and evicting their owners, and answers owner lookups.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                            | handshake
//  req     | in  | command, owner_id, block_width, data_bytes         | valid/ready
//  rsp     | out | status, block_addr, block_bytes, owner_valid,      | valid/ready
//          |     | stored_width, thrash                               |
//
// Alloc walks the blocks from the rover, reading size and owner of each absorbed
// block and the owner slot of each block that has an owner; the size/owner RAM
// ports set this walk. A zero-size or oversize alloc ends after the size check.
// Lookup reads the owner slot, then size and width (a miss ends after the slot read);
// frame mark answers from idle. Flush and reset run a clearing pass over
// max(ARENA_BYTES/4, OWNER_SLOTS) entries (16384 by default) with req.ready low. One
// command is in flight at a time; req.ready stays low until the previous result has been taken on rsp.
// ----------------------------------------------------------------------------
module rover_block_cache_allocator #(
	parameter int ARENA_BYTES  = 65536,
	parameter int HEADER_BYTES = 32,
	parameter int FRAGMENT_MIN = 256,
	parameter int OWNER_SLOTS  = 1024
) (
	input logic       clk,
	input logic       arst_n,
	rbca_req_if.sink   req,
	rbca_rsp_if.source rsp
);
	import rbca_pkg::*;

	localparam int NBLK  = ARENA_BYTES / 4;
	localparam int IW    = $clog2(NBLK);
	localparam int RW    = IW + 1;
	localparam int SW    = $clog2(ARENA_BYTES) + 1;
	localparam int OW    = $clog2(OWNER_SLOTS);
	localparam int NW    = ((SW > 18) ? SW : 18) + 1;
	localparam int CLR_N = (NBLK > OWNER_SLOTS) ? NBLK : OWNER_SLOTS;
	localparam int CTW   = $clog2(CLR_N);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHK, S_RD, S_SLOT, S_NEXT, S_FIN, S_FIN2, S_FIN3,
		S_LK0, S_LK1, S_LK2
	} state_t;

	state_t state_q;

	logic [OID_W-1:0]  oid_q;
	logic [WID_W-1:0]  wid_q;
	logic [DATA_W-1:0] data_q;
	logic [NW-1:0]     need_q;
	logic [IW-1:0]     nb_q;
	logic [IW-1:0]     cur_q;
	logic [SW-1:0]     total_q;
	logic              first_q;
	logic [OW-1:0]     own_o_q;
	logic              wrap_now_q;
	logic [SW-1:0]     bsize_q;
	logic [RW-1:0]     rover_q;
	logic [RW-1:0]     frame_q;
	logic              wrapped_q;
	logic              thrash_q;
	logic [CTW-1:0]    clr_q;
	logic              flush_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic                ovalid_q;
	logic [WID_W-1:0]    swidth_q;
	logic                othrash_q;

	// RAM ports
	logic          s_we, o_we, w_we, t_we;
	logic [IW-1:0] s_waddr, s_raddr, o_waddr, o_raddr, w_waddr, w_raddr;
	logic [OW-1:0] t_waddr, t_raddr;
	logic [SW-1:0] s_wdata, s_rdata;
	logic [OW:0]   o_wdata, o_rdata;
	logic [WID_W-1:0] w_wdata, w_rdata;
	logic [RW-1:0] t_wdata, t_rdata;

	rbca_ram #(.WIDTH(SW), .DEPTH(NBLK)) u_size (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
	);
	rbca_ram #(.WIDTH(OW + 1), .DEPTH(NBLK)) u_owner (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata)
	);
	rbca_ram #(.WIDTH(WID_W), .DEPTH(NBLK)) u_width (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
	);
	rbca_ram #(.WIDTH(RW), .DEPTH(OWNER_SLOTS)) u_slot (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
	);

	function automatic logic [RW:0] rank(input logic [RW-1:0] r);
		return (r >= RW'(NBLK)) ? '0 : ((RW + 1)'(r) + 1'b1);
	endfunction

	// shared decode
	logic [NW-1:0]   need_in;
	logic            oid_ok;
	logic [OW-1:0]   oid_idx;
	logic            rover_past;
	logic            wrap_cond;
	logic [IW-1:0]   nb_pre;
	logic            rd_break;
	logic            own_hit;
	logic [SW:0]     total_sum;
	logic [IW+1:0]   nxt;
	logic            nxt_end;
	logic            short;
	logic [NW-1:0]   rem;
	logic            split;
	logic [IW-1:0]   frag;
	logic            th_new;
	logic            clr_last;

	assign need_in = (NW'(HEADER_BYTES) + NW'(req.data_bytes) + NW'(3)) & ~NW'(3);
	assign oid_ok = 32'(oid_q) < OWNER_SLOTS;
	assign oid_idx = OW'(oid_q);
	assign rover_past = rover_q >= RW'(NBLK);
	assign wrap_cond = ((NW + 1)'({rover_q, 2'b00}) + (NW + 1)'(need_q)) >
		(NW + 1)'(ARENA_BYTES);
	assign nb_pre = (rover_past || wrap_cond) ? '0 : IW'(rover_q);
	assign rd_break = !first_q && (s_rdata == '0);
	assign own_hit = o_rdata[OW] && (32'(o_rdata[OW-1:0]) < OWNER_SLOTS);
	assign total_sum = (SW + 1)'(total_q) + (SW + 1)'(s_rdata);
	assign nxt = (IW + 2)'(nb_q) + (IW + 2)'(total_q >> 2);
	assign nxt_end = nxt >= (IW + 2)'(NBLK);
	assign short = NW'(total_q) < need_q;
	assign rem = NW'(total_q) - need_q;
	assign split = (NW'(total_q) > need_q) && (rem > NW'(FRAGMENT_MIN));
	assign frag = IW'((IW + 2)'(nb_q) + (IW + 2)'(need_q >> 2));
	assign th_new = thrash_q || (wrapped_q && (wrap_now_q || (rank(rover_q) >= rank(frame_q))));
	assign clr_last = clr_q == CTW'(CLR_N - 1);

	always_comb begin
		s_we = 1'b0; s_waddr = nb_q; s_wdata = '0; s_raddr = cur_q;
		o_we = 1'b0; o_waddr = cur_q; o_wdata = '0; o_raddr = cur_q;
		w_we = 1'b0; w_waddr = nb_q; w_wdata = '0; w_raddr = cur_q;
		t_we = 1'b0; t_waddr = oid_idx; t_wdata = '0; t_raddr = oid_idx;
		case (state_q)
			S_CLR: begin
				if (32'(clr_q) < NBLK) begin
					s_we = 1'b1;
					s_waddr = IW'(clr_q);
					s_wdata = (clr_q == '0) ? SW'(ARENA_BYTES) : '0;
					o_we = 1'b1;
					o_waddr = IW'(clr_q);
				end
				if (32'(clr_q) < OWNER_SLOTS) begin
					t_we = 1'b1;
					t_waddr = OW'(clr_q);
				end
			end
			S_CHK: begin
				s_raddr = nb_pre;
				o_raddr = nb_pre;
			end
			S_RD: begin
				if (!rd_break) begin
					if (own_hit) begin
						t_raddr = o_rdata[OW-1:0];
					end else begin
						o_we = 1'b1;
					end
				end
			end
			S_SLOT: begin
				o_we = 1'b1;
				if (t_rdata == {1'b1, cur_q}) begin
					t_we = 1'b1;
					t_waddr = own_o_q;
				end
			end
			S_NEXT: begin
				s_raddr = IW'(nxt);
				o_raddr = IW'(nxt);
			end
			S_FIN: begin
				if (split) begin
					s_we = 1'b1; s_waddr = frag; s_wdata = SW'(rem);
					w_we = 1'b1; w_waddr = frag;
					o_we = 1'b1; o_waddr = frag;
				end
			end
			S_FIN2: begin
				s_we = 1'b1; s_wdata = bsize_q;
				w_we = 1'b1; w_wdata = wid_q;
				if (oid_ok && t_rdata[IW]) begin
					o_we = 1'b1;
					o_waddr = t_rdata[IW-1:0];
				end
				if (oid_ok) begin
					t_we = 1'b1;
					t_wdata = {1'b1, nb_q};
				end
			end
			S_FIN3: begin
				o_we = 1'b1;
				o_waddr = nb_q;
				o_wdata = oid_ok ? {1'b1, oid_idx} : '0;
			end
			S_LK1: begin
				s_raddr = t_rdata[IW-1:0];
				w_raddr = t_rdata[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.block_addr = addr_q;
	assign rsp.block_bytes = bytes_q;
	assign rsp.owner_valid = ovalid_q;
	assign rsp.stored_width = swidth_q;
	assign rsp.thrash = othrash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			flush_q <= 1'b0;
			rover_q <= '0;
			frame_q <= '0;
			wrapped_q <= 1'b0;
			thrash_q <= 1'b0;
			out_valid_q <= 1'b0;
			first_q <= 1'b0;
			wrap_now_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_last) begin
						clr_q <= '0;
						state_q <= S_IDLE;
						if (flush_q) begin
							flush_q <= 1'b0;
							out_valid_q <= 1'b1;
							status_q <= ST_OK;
							addr_q <= '0; bytes_q <= '0; ovalid_q <= 1'b0; swidth_q <= '0;
							othrash_q <= thrash_q;
						end
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						oid_q <= req.owner_id;
						wid_q <= req.block_width;
						data_q <= req.data_bytes;
						need_q <= need_in;
						case (cmd_t'(req.command))
							CMD_ALLOC: state_q <= S_CHK;
							CMD_FLUSH: begin
								flush_q <= 1'b1;
								rover_q <= '0;
								state_q <= S_CLR;
							end
							CMD_LOOKUP: state_q <= S_LK0;
							default: begin
								frame_q <= rover_q;
								wrapped_q <= 1'b0;
								thrash_q <= 1'b0;
								out_valid_q <= 1'b1;
								status_q <= ST_OK;
								addr_q <= '0; bytes_q <= '0; ovalid_q <= 1'b0; swidth_q <= '0;
								othrash_q <= 1'b0;
							end
						endcase
					end
				end
				S_CHK: begin
					if (data_q == '0 || need_q > NW'(ARENA_BYTES)) begin
						out_valid_q <= 1'b1;
						status_q <= (data_q == '0) ? ST_ZERO : ST_OVERSIZE;
						addr_q <= '0; bytes_q <= '0; ovalid_q <= 1'b0; swidth_q <= '0;
						othrash_q <= thrash_q;
						state_q <= S_IDLE;
					end else begin
						wrap_now_q <= !rover_past && wrap_cond;
						nb_q <= nb_pre;
						cur_q <= nb_pre;
						first_q <= 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					first_q <= 1'b0;
					if (rd_break) begin
						state_q <= S_FIN;
					end else begin
						total_q <= first_q ? s_rdata : SW'(total_sum);
						own_o_q <= o_rdata[OW-1:0];
						state_q <= own_hit ? S_SLOT : S_NEXT;
					end
				end
				S_SLOT: state_q <= S_NEXT;
				S_NEXT: begin
					if (short && !nxt_end) begin
						cur_q <= IW'(nxt);
						state_q <= S_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (split) begin
						bsize_q <= SW'(need_q);
						rover_q <= RW'(frag);
					end else begin
						bsize_q <= total_q;
						rover_q <= (nxt > (IW + 2)'(NBLK)) ? RW'(NBLK) : RW'(nxt);
					end
					state_q <= S_FIN2;
				end
				S_FIN2: state_q <= S_FIN3;
				S_FIN3: begin
					thrash_q <= th_new;
					if (!wrapped_q && wrap_now_q) begin
						wrapped_q <= 1'b1;
					end
					out_valid_q <= 1'b1;
					status_q <= ST_OK;
					addr_q <= ADDR_W'({nb_q, 2'b00});
					bytes_q <= BYTES_W'(bsize_q);
					ovalid_q <= oid_ok;
					swidth_q <= wid_q;
					othrash_q <= th_new;
					state_q <= S_IDLE;
				end
				S_LK0: state_q <= S_LK1;
				S_LK1: begin
					if (oid_ok && t_rdata[IW]) begin
						cur_q <= t_rdata[IW-1:0];
						state_q <= S_LK2;
					end else begin
						out_valid_q <= 1'b1;
						status_q <= ST_OK;
						addr_q <= '0; bytes_q <= '0; ovalid_q <= 1'b0; swidth_q <= '0;
						othrash_q <= thrash_q;
						state_q <= S_IDLE;
					end
				end
				S_LK2: begin
					out_valid_q <= 1'b1;
					status_q <= ST_OK;
					addr_q <= ADDR_W'({cur_q, 2'b00});
					bytes_q <= BYTES_W'(s_rdata);
					ovalid_q <= 1'b1;
					swidth_q <= w_rdata;
					othrash_q <= thrash_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
